/* sv/u8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file but u8d_byte_if imports this package.
package u8d_pkg;

  localparam int unsigned CP_W    = 31;
  localparam int unsigned TALLY_W = 4;
  localparam int unsigned CNT_W   = 3;

  localparam logic [TALLY_W-1:0] TALLY_MAX = 4'd15;

  // Continuation bytes awaited after each lead form
  localparam logic [CNT_W-1:0] AWAIT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] AWAIT_TWO  = 3'd1;
  localparam logic [CNT_W-1:0] AWAIT_THREE = 3'd2;
  localparam logic [CNT_W-1:0] AWAIT_FOUR = 3'd3;
  localparam logic [CNT_W-1:0] AWAIT_FIVE = 3'd4;
  localparam logic [CNT_W-1:0] AWAIT_SIX  = 3'd5;

  // One raw byte beat held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } byte_beat_t;

  // One decoded result beat
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               stray_byte;
    logic [TALLY_W-1:0] consumed_bytes;
  } result_t;

endpackage

/* sv/u8d_byte_if.sv */
// Valid/ready channel carrying one raw stream byte per beat.
// Depends on nothing but the wire types.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* sv/u8d_result_if.sv */
// Valid/ready channel carrying one decoded code point per beat.
// Depends on u8d_pkg for field widths.
interface u8d_result_if;
  import u8d_pkg::*;

  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    code_point;
  logic               stray_byte;
  logic [TALLY_W-1:0] consumed_bytes;

  modport source (output valid, output code_point, output stray_byte,
                  output consumed_bytes, input ready);
  modport sink   (input valid, input code_point, input stray_byte,
                  input consumed_bytes, output ready);
endinterface

/* sv/utf8_stream_decoder.sv */
// UTF-8 stream decoder, top level: original UTF-8 with 1 to 6 byte sequences.
// Depends on u8d_pkg, u8d_byte_if, u8d_result_if, u8d_in_reg, u8d_core.
//
// Usage:
//   in_bus carries one raw byte per beat (data_byte). out_bus carries one
//   decoded code point per beat with stray_byte and consumed_bytes.
//   Continuation bytes and lead bytes that do not finish a sequence give no
//   beat; ASCII, the last awaited continuation, stray continuations and the
//   bytes 0xFE/0xFF each give one.
//   A byte accepted on in_bus is held in the input register, then decoded
//   into the result register, from which out_bus presents its result.
//   Throughput: one byte per cycle while out_bus.ready stays high; the
//   sequence state updates in a single pass of decode logic.
//   Reset (rst_n low, synchronous) clears the partial code point, awaited
//   count, byte tally and both valid flags.
//   When the receiver stalls, the result register holds its beat, and the
//   input register still takes one more byte; after that in_bus.ready drops
//   until the result drains.
module utf8_stream_decoder (
  input logic          clk,
  input logic          rst_n,
  u8d_byte_if.sink     in_bus,
  u8d_result_if.source out_bus
);
  import u8d_pkg::*;

  byte_beat_t beat;
  result_t    result;
  logic       take;

  u8d_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_data_byte (in_bus.data_byte),
    .in_ready     (in_bus.ready),
    .take         (take),
    .beat         (beat)
  );

  u8d_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .take      (take),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .result    (result)
  );

  assign out_bus.code_point     = result.code_point;
  assign out_bus.stray_byte     = result.stray_byte;
  assign out_bus.consumed_bytes = result.consumed_bytes;
endmodule

/* sv/u8d_in_reg.sv */
// Input register: captures one byte beat and holds it until the core takes it.
// Depends on u8d_pkg.
module u8d_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  output logic                in_ready,
  input  logic                take,
  output u8d_pkg::byte_beat_t beat
);
  import u8d_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !valid_r || take;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data_byte;
    end
  end

  assign beat.valid     = valid_r;
  assign beat.data_byte = data_r;
endmodule

/* sv/u8d_core.sv */
// Decode core: sequence state, byte classification and the result register.
// Depends on u8d_pkg.
module u8d_core (
  input  logic                clk,
  input  logic                rst_n,
  input  u8d_pkg::byte_beat_t beat,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output u8d_pkg::result_t    result
);
  import u8d_pkg::*;

  logic [CP_W-1:0]    partial_r, partial_nxt;
  logic [CNT_W-1:0]   awaited_r, awaited_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               out_valid_r;
  result_t            result_r, result_nxt;
  logic               emit;
  logic [TALLY_W-1:0] tally_inc;
  logic [CP_W-1:0]    shifted;
  logic [CNT_W-1:0]   awaited_dec;
  logic [7:0]         c;

  // Advance when the result register is free or drains this cycle
  assign take = beat.valid && (!out_valid_r || out_ready);

  assign c           = beat.data_byte;
  assign tally_inc   = (tally_r == TALLY_MAX) ? TALLY_MAX : tally_r + 4'd1;
  assign shifted     = {partial_r[CP_W-7:0], c[5:0]};
  assign awaited_dec = awaited_r - 3'd1;

  // Classify the byte and work out the next sequence state
  always_comb begin
    emit        = 1'b0;
    result_nxt  = '{code_point: {23'd0, c}, stray_byte: 1'b0, consumed_bytes: tally_inc};
    partial_nxt = partial_r;
    awaited_nxt = awaited_r;
    unique case (c) inside
      8'b0???????: begin
        emit = 1'b1;
      end
      8'b10??????: begin
        if (awaited_r == AWAIT_NONE) begin
          emit                  = 1'b1;
          result_nxt.stray_byte = 1'b1;
        end else if (awaited_dec == AWAIT_NONE) begin
          emit                  = 1'b1;
          result_nxt.code_point = shifted;
        end else begin
          partial_nxt = shifted;
          awaited_nxt = awaited_dec;
        end
      end
      8'b110?????: begin
        partial_nxt = {26'd0, c[4:0]};
        awaited_nxt = AWAIT_TWO;
      end
      8'b1110????: begin
        partial_nxt = {27'd0, c[3:0]};
        awaited_nxt = AWAIT_THREE;
      end
      8'b11110???: begin
        partial_nxt = {28'd0, c[2:0]};
        awaited_nxt = AWAIT_FOUR;
      end
      8'b111110??: begin
        partial_nxt = {29'd0, c[1:0]};
        awaited_nxt = AWAIT_FIVE;
      end
      8'b1111110?: begin
        partial_nxt = {30'd0, c[0]};
        awaited_nxt = AWAIT_SIX;
      end
      default: begin
        // 0xFE and 0xFF fit no sequence
        emit                  = 1'b1;
        result_nxt.stray_byte = 1'b1;
      end
    endcase
    tally_nxt = tally_inc;
    if (emit) begin
      partial_nxt = '0;
      awaited_nxt = AWAIT_NONE;
      tally_nxt   = '0;
    end
  end

  // Hold sequence state; advance only on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      awaited_r <= AWAIT_NONE;
      tally_r   <= '0;
    end else if (take) begin
      partial_r <= partial_nxt;
      awaited_r <= awaited_nxt;
      tally_r   <= tally_nxt;
    end
  end

  // Result register: drop valid once the beat is taken, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;
endmodule
